>>> hdl/tlptw_pkg.sv
package tlptw_pkg;

  localparam logic CMD_WRITE     = 1'b0;
  localparam logic CMD_TRANSLATE = 1'b1;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_INVALID    = 2'd1;
  localparam logic [1:0] ST_SUPERVISOR = 2'd2;
  localparam logic [1:0] ST_PTR_LAST   = 2'd3;

  localparam logic [1:0] ET_INVALID  = 2'd0;
  localparam logic [1:0] ET_PTD      = 2'd1;
  localparam logic [1:0] ET_PTE      = 2'd2;
  localparam logic [1:0] ET_RESERVED = 2'd3;

  localparam logic [1:0] LVL_FIRST  = 2'd0;
  localparam logic [1:0] LVL_SECOND = 2'd1;
  localparam logic [1:0] LVL_LAST   = 2'd2;

  localparam logic [2:0] ACC_SUPER_MIN = 3'd6;

  localparam logic [31:0] MASK_LVL0 = 32'h00FF_FFFF;
  localparam logic [31:0] MASK_LVL1 = 32'h0003_FFFF;
  localparam logic [31:0] MASK_LVL2 = 32'h0000_0FFF;

  typedef struct packed {
    logic        cmd;
    logic [11:0] word_index;
    logic [31:0] word_data;
    logic [31:0] virt_addr;
  } in_item_t;

  typedef struct packed {
    logic [31:0] phys_addr;
    logic [1:0]  status;
  } out_item_t;

  typedef struct packed {
    logic       wr_en;
    logic       walk_start;
    logic       walk_next;
    logic       finish;
    logic [1:0] level;
  } ctrl_t;

  typedef struct packed {
    logic is_ptd;
  } stat_t;

endpackage

>>> hdl/tlptw_ctrl.sv
module tlptw_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 in_cmd,
  input  tlptw_pkg::stat_t     stat,
  output logic                 busy,
  output tlptw_pkg::ctrl_t     ctrl
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_WALK = 1'b1;

  logic       state_r;
  logic       state_nxt;
  logic [1:0] level_r;
  logic [1:0] level_nxt;

  assign busy = (state_r == S_WALK);

  always_comb begin
    state_nxt       = state_r;
    level_nxt       = level_r;
    ctrl.wr_en      = 1'b0;
    ctrl.walk_start = 1'b0;
    ctrl.walk_next  = 1'b0;
    ctrl.finish     = 1'b0;
    ctrl.level      = level_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_cmd == tlptw_pkg::CMD_TRANSLATE) begin
            ctrl.walk_start = 1'b1;
            level_nxt       = tlptw_pkg::LVL_FIRST;
            state_nxt       = S_WALK;
          end else begin
            ctrl.wr_en = 1'b1;
          end
        end
      end
      S_WALK: begin
        if (stat.is_ptd && (level_r != tlptw_pkg::LVL_LAST)) begin
          ctrl.walk_next = 1'b1;
          level_nxt      = level_r + 2'd1;
        end else begin
          ctrl.finish = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      level_r <= tlptw_pkg::LVL_FIRST;
    end else begin
      state_r <= state_nxt;
      level_r <= level_nxt;
    end
  end

endmodule

>>> hdl/tlptw_dp.sv
module tlptw_dp #(
  parameter int MEM_WORDS = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tlptw_pkg::in_item_t   in_item,
  input  logic                  cfg_valid,
  input  logic [31:0]           cfg_data,
  input  tlptw_pkg::ctrl_t      ctrl,
  output tlptw_pkg::stat_t      stat,
  output logic                  out_valid,
  output tlptw_pkg::out_item_t  out_item
);

  // The depth is taken to be a power of two, so word addresses wrap by truncation.
  localparam int AW = $clog2(MEM_WORDS);

  logic [31:0]            mem [MEM_WORDS];
  logic [31:0]            mem_q_r;
  logic [31:0]            root_r;
  logic [31:0]            va_r;
  logic                   out_valid_r;
  tlptw_pkg::out_item_t   out_r;
  tlptw_pkg::out_item_t   out_nxt;

  logic [29:0]            rd_base;
  logic [7:0]             rd_idx;
  logic [31:0]            rd_sum;
  logic [AW-1:0]          rd_addr;
  logic [31:0]            wr_ext;
  logic [AW-1:0]          wr_addr;
  logic                   rd_en;
  logic [1:0]             etype;
  logic [31:0]            mask;
  logic [31:0]            pa;

  assign etype = mem_q_r[1:0];
  assign stat.is_ptd = (etype == tlptw_pkg::ET_PTD);

  always_comb begin
    if (ctrl.walk_start) begin
      rd_base = root_r[31:2];
      rd_idx  = in_item.virt_addr[31:24];
    end else begin
      rd_base = {mem_q_r[27:2], 4'b0000};
      if (ctrl.level == tlptw_pkg::LVL_FIRST) begin
        rd_idx = {2'b00, va_r[23:18]};
      end else begin
        rd_idx = {2'b00, va_r[17:12]};
      end
    end
  end

  assign rd_sum  = {2'b00, rd_base} + {24'd0, rd_idx};
  assign rd_addr = rd_sum[AW-1:0];
  assign rd_en   = ctrl.walk_start | ctrl.walk_next;
  assign wr_ext  = {20'd0, in_item.word_index};
  assign wr_addr = wr_ext[AW-1:0];

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[wr_addr] <= in_item.word_data;
    end
    if (rd_en) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  always_comb begin
    case (ctrl.level)
      tlptw_pkg::LVL_FIRST:  mask = tlptw_pkg::MASK_LVL0;
      tlptw_pkg::LVL_SECOND: mask = tlptw_pkg::MASK_LVL1;
      default:               mask = tlptw_pkg::MASK_LVL2;
    endcase
  end

  assign pa = ({mem_q_r[27:0], 4'b0000} & ~mask) | (va_r & mask);

  always_comb begin
    out_nxt.phys_addr = 32'd0;
    out_nxt.status    = tlptw_pkg::ST_INVALID;
    case (etype)
      tlptw_pkg::ET_PTD: begin
        out_nxt.status = tlptw_pkg::ST_PTR_LAST;
      end
      tlptw_pkg::ET_PTE: begin
        if (mem_q_r[4:2] < tlptw_pkg::ACC_SUPER_MIN) begin
          out_nxt.phys_addr = pa;
          out_nxt.status    = tlptw_pkg::ST_OK;
        end else begin
          out_nxt.status = tlptw_pkg::ST_SUPERVISOR;
        end
      end
      default: begin
        out_nxt.status = tlptw_pkg::ST_INVALID;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.walk_start) begin
      va_r <= in_item.virt_addr;
    end
    if (ctrl.finish) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r      <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        root_r <= cfg_data;
      end
      out_valid_r <= ctrl.finish;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

>>> hdl/three_level_page_table_walk.sv
// A table write gives no result; busy stays low.
// A translation reads one table level a cycle from the single memory read port,
// so busy is high while the walk lasts and out_valid rises in the cycle that busy falls.
// A new request is taken only while busy is low, so one translation ends before the next starts.
// Reset clears the root address and the controller; the table is undefined until written.
// The result is shown for exactly one cycle; the receiver cannot stall it.
module three_level_page_table_walk #(
  parameter int MEM_WORDS = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  tlptw_pkg::in_item_t   in_item,
  output logic                  out_valid,
  output tlptw_pkg::out_item_t  out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [31:0]           cfg_data
);

  tlptw_pkg::ctrl_t ctrl;
  tlptw_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  tlptw_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_cmd (in_item.cmd),
    .stat   (stat),
    .busy   (busy),
    .ctrl   (ctrl)
  );

  tlptw_dp #(
    .MEM_WORDS (MEM_WORDS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .ctrl      (ctrl),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("Result shown while a walk is still in progress.");

  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_item.cmd == tlptw_pkg::CMD_WRITE)) |=> !out_valid)
    else $error("A table write produced a result.");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("Result strobe held for more than one cycle.");

  a_fault_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.status != tlptw_pkg::ST_OK)) |-> (out_item.phys_addr == 32'd0))
    else $error("Faulting transaction carries a non-zero physical address.");

endmodule

>>> tb/testbench.sv
module testbench;

  localparam int MEM_WORDS = 4096;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  tlptw_pkg::in_item_t  in_item = '0;
  logic                 out_valid;
  tlptw_pkg::out_item_t out_item;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [31:0]          cfg_data = '0;

  three_level_page_table_walk #(
    .MEM_WORDS(MEM_WORDS)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // Table contents as the block should hold them, and as they will be once the queue drains.
  logic [31:0] live_mem [MEM_WORDS];
  logic [31:0] plan_mem [MEM_WORDS];
  bit          plan_set [MEM_WORDS];
  logic [31:0] live_root = '0;
  logic [31:0] plan_root = '0;

  tlptw_pkg::in_item_t  pend_q[$];
  tlptw_pkg::out_item_t pending_xlat[$];
  logic [31:0]          used_va[$];

  int n_items = 0;
  int n_sent = 0;
  int n_roots = 0;
  int errors = 0;
  int seen_status [4];
  int gap_left = 0;
  int calm_left = 0;

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    errors++;
    $display("MISMATCH %s: got %h, expected %h", what, got, want);
  endtask

  function automatic logic [11:0] word_at(input logic [31:0] tbl, input int lvl,
                                          input logic [31:0] va);
    logic [11:0] idx;
    case (lvl)
      tlptw_pkg::LVL_FIRST:  idx = {4'b0, va[31:24]};
      tlptw_pkg::LVL_SECOND: idx = {6'b0, va[23:18]};
      default:               idx = {6'b0, va[17:12]};
    endcase
    return tbl[13:2] + idx;
  endfunction

  // Walks either the live table or the planned one; blind marks a read of an unset word of the plan.
  function automatic tlptw_pkg::out_item_t translate_va(input bit on_plan,
                                                        input logic [31:0] root,
                                                        input logic [31:0] va,
                                                        output bit blind);
    tlptw_pkg::out_item_t res;
    logic [31:0]          tbl;
    logic [31:0]          mask;
    logic [31:0]          e;
    logic [11:0]          w;
    bit                   done;
    int                   lvl;
    tbl = root;
    mask = tlptw_pkg::MASK_LVL0;
    blind = 1'b0;
    done = 1'b0;
    res.phys_addr = '0;
    res.status = tlptw_pkg::ST_PTR_LAST;
    for (lvl = 0; lvl < 3 && !done; lvl++) begin
      w = word_at(tbl, lvl, va);
      if (on_plan && !plan_set[w]) blind = 1'b1;
      e = on_plan ? plan_mem[w] : live_mem[w];
      case (e[1:0])
        tlptw_pkg::ET_PTD: begin
          mask = mask >> 6;
          tbl = {e[27:2], 6'b0};
        end
        tlptw_pkg::ET_PTE: begin
          if (e[4:2] < tlptw_pkg::ACC_SUPER_MIN) begin
            res.phys_addr = ({e[27:0], 4'b0} & ~mask) | (va & mask);
            res.status = tlptw_pkg::ST_OK;
          end else begin
            res.status = tlptw_pkg::ST_SUPERVISOR;
          end
          done = 1'b1;
        end
        default: begin
          res.status = tlptw_pkg::ST_INVALID;
          done = 1'b1;
        end
      endcase
    end
    return res;
  endfunction

  function automatic void push_write(input logic [11:0] idx, input logic [31:0] data);
    tlptw_pkg::in_item_t it;
    it.cmd = tlptw_pkg::CMD_WRITE;
    it.word_index = idx;
    it.word_data = data;
    it.virt_addr = $urandom;
    plan_mem[idx] = data;
    plan_set[idx] = 1'b1;
    pend_q.push_back(it);
    n_items++;
  endfunction

  function automatic bit push_translate(input logic [31:0] va);
    tlptw_pkg::in_item_t  it;
    tlptw_pkg::out_item_t res;
    bit                   blind;
    res = translate_va(1'b1, plan_root, va, blind);
    if (blind) return 1'b0;
    it.cmd = tlptw_pkg::CMD_TRANSLATE;
    it.word_index = 12'($urandom);
    it.word_data = $urandom;
    it.virt_addr = va;
    pend_q.push_back(it);
    n_items++;
    return 1'b1;
  endfunction

  function automatic logic [31:0] pte(input logic [2:0] acc);
    logic [31:0] e;
    e = $urandom;
    e[4:2] = acc;
    e[1:0] = tlptw_pkg::ET_PTE;
    return e;
  endfunction

  function automatic logic [31:0] rand_leaf(input int depth);
    logic [31:0] e;
    int          r;
    r = $urandom_range(0, 9);
    e = $urandom;
    if (r == 0) begin
      e[1:0] = $urandom_range(0, 1) ? tlptw_pkg::ET_INVALID : tlptw_pkg::ET_RESERVED;
    end else if (r == 1 && depth == tlptw_pkg::LVL_LAST) begin
      e[1:0] = tlptw_pkg::ET_PTD;
    end else begin
      e[1:0] = tlptw_pkg::ET_PTE;
    end
    return e;
  endfunction

  // Lays down pointers from the root down to the given level, places the leaf and translates.
  function automatic void chain(input logic [31:0] va, input int depth,
                                input logic [31:0] leaf);
    logic [31:0] tbl;
    logic [31:0] e;
    int          lvl;
    tbl = plan_root;
    for (lvl = 0; lvl < depth; lvl++) begin
      e = $urandom;
      e[1:0] = tlptw_pkg::ET_PTD;
      push_write(word_at(tbl, lvl, va), e);
      tbl = {e[27:2], 6'b0};
    end
    push_write(word_at(tbl, depth, va), leaf);
    used_va.push_back(va);
    void'(push_translate(va));
  endfunction

  function automatic void fill_phase(input int quota);
    logic [31:0] va;
    int          stop;
    int          pick;
    int          d;
    int          k;
    bit          ok;
    stop = n_items + quota;
    while (n_items < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        d = $urandom_range(0, 2);
        va = $urandom;
        chain(va, d, rand_leaf(d));
        repeat ($urandom_range(0, 2))
          void'(push_translate(va ^ ($urandom & (32'h00FF_FFFF >> (6 * d)))));
        if ($urandom_range(0, 1)) void'(push_translate(va ^ ($urandom & 32'h00FF_FFFF)));
      end else if (pick < 85) begin
        ok = 1'b0;
        for (k = 0; k < 4 && !ok; k++) begin
          if (used_va.size() != 0 && $urandom_range(0, 2) != 0)
            va = used_va[$urandom_range(0, used_va.size() - 1)] ^ ($urandom & 32'h00FF_FFFF);
          else
            va = $urandom;
          ok = push_translate(va);
        end
      end else begin
        push_write(12'($urandom_range(0, MEM_WORDS - 1)), $urandom);
      end
    end
  endfunction

  function automatic int next_gap();
    int r;
    if (calm_left != 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) calm_left = $urandom_range(20, 60);
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic set_root(input logic [31:0] v);
    while (pend_q.size() != 0 || start || pending_xlat.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    live_root = v;
    plan_root = v;
    n_roots++;
  endtask

  always @(posedge clk) begin : drive
    bit blind;
    if (!rst_n) begin
      start <= 1'b0;
      gap_left <= 0;
    end else begin
      if (start && !busy) begin
        n_sent++;
        if (in_item.cmd == tlptw_pkg::CMD_WRITE)
          live_mem[in_item.word_index] = in_item.word_data;
        else
          pending_xlat.push_back(translate_va(1'b0, live_root, in_item.virt_addr, blind));
      end
      if (!(start && busy)) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          start <= 1'b0;
        end else if (pend_q.size() != 0) begin
          in_item <= pend_q.pop_front();
          start <= 1'b1;
          gap_left <= next_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : watch
    tlptw_pkg::out_item_t want;
    if (rst_n && out_valid) begin
      if (pending_xlat.size() == 0) begin
        note_mismatch("result with no translation outstanding", out_item.phys_addr, '0);
      end else begin
        want = pending_xlat.pop_front();
        seen_status[want.status]++;
        if (out_item.phys_addr !== want.phys_addr)
          note_mismatch("phys_addr", out_item.phys_addr, want.phys_addr);
        if (out_item.status !== want.status)
          note_mismatch("status", {30'b0, out_item.status}, {30'b0, want.status});
      end
    end
  end

  initial begin : stimulus
    logic [31:0] roots [6];
    int          p;
    int          k;
    roots[0] = $urandom;
    roots[1] = 32'hFFFF_FFFF;
    roots[2] = 32'h0000_0000;
    roots[3] = 32'hFFFF_FFC0;
    roots[4] = $urandom & 32'h0000_FFFC;
    roots[5] = $urandom;

    push_write(12'd4095, 32'hFFFF_FFFF);
    chain(32'h0000_0000, tlptw_pkg::LVL_FIRST, 32'h0000_0000);
    chain(32'hFFFF_FFFF, tlptw_pkg::LVL_FIRST, 32'hFFFF_FFFF);
    chain($urandom, tlptw_pkg::LVL_FIRST, pte(3'd0));
    chain($urandom, tlptw_pkg::LVL_SECOND, pte(3'd5));
    chain($urandom, tlptw_pkg::LVL_LAST, pte(3'd2));
    chain($urandom, tlptw_pkg::LVL_FIRST, pte(3'd6));
    chain($urandom, tlptw_pkg::LVL_LAST, pte(3'd7));
    chain($urandom, tlptw_pkg::LVL_LAST, ({$urandom} | 32'd1) & ~32'd2);
    chain($urandom, tlptw_pkg::LVL_SECOND, 32'hFFFF_FFE2);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (p = 0; p < 6; p++) begin
      set_root(roots[p]);
      fill_phase(250);
    end

    while (pend_q.size() != 0 || start) @(posedge clk);
    for (k = 0; k < 200 && pending_xlat.size() != 0; k++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (pending_xlat.size() != 0)
      note_mismatch("translations never answered", pending_xlat.size(), '0);

    $display("%0d transactions driven under %0d root settings after reset.", n_sent, n_roots);
    $display("Translations: %0d mapped, %0d invalid, %0d refused, %0d pointer at last level.",
             seen_status[tlptw_pkg::ST_OK], seen_status[tlptw_pkg::ST_INVALID],
             seen_status[tlptw_pkg::ST_SUPERVISOR], seen_status[tlptw_pkg::ST_PTR_LAST]);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #6000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
